/* rtl/core/sdd_pkg.sv */
// Shared types, constants and the divisor table for the scaled decimal to double converter.
// No dependencies; every other file in rtl/core depends on this package.
package sdd_pkg;

	localparam int MAX_SCALE   = 38;
	localparam int SCALE_W     = 6;
	localparam int WORD_W      = 64;
	localparam int MAG_W       = 2 * WORD_W;
	localparam int LEN_W       = 8;
	localparam int MANT_W      = 53;
	localparam int FRAC_W      = 52;
	localparam int EXP_W       = 11;
	localparam int EXPC_W      = 12;
	localparam int BIAS        = 1023;
	localparam int REM_W       = MANT_W + 1;
	localparam int QUO_W       = MANT_W + 2;
	localparam int DIV_STEPS   = QUO_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// one classified item handed from the front to the back
	typedef struct packed {
		logic [MANT_W-1:0] num_mant;
		logic [EXP_W-1:0]  num_exp;
		logic [MANT_W-1:0] den_mant;
		logic [EXP_W-1:0]  den_exp;
		logic              num_zero;
		logic              positive;
	} entry_t;

	typedef logic [WORD_W-1:0] den_table_t [0:MAX_SCALE];

	// double of ten to each scale, rounded to nearest even; built at elaboration
	function automatic den_table_t build_den_table();
		den_table_t        t;
		logic [MAG_W-1:0]  p;
		logic [MAG_W-1:0]  norm;
		int                n;
		logic [MANT_W-1:0] m;
		logic              rb;
		logic              st;
		logic [MANT_W:0]   mr;
		logic [EXP_W-1:0]  e;
		p = MAG_W'(1);
		for (int s = 0; s <= MAX_SCALE; s++) begin
			n = 0;
			for (int b = 0; b < MAG_W; b++) begin
				if (p[b]) n = b + 1;
			end
			norm = p << (MAG_W - n);
			m    = norm[MAG_W-1 -: MANT_W];
			rb   = norm[MAG_W-1-MANT_W];
			st   = |norm[MAG_W-2-MANT_W:0];
			mr   = {1'b0, m};
			e    = EXP_W'(BIAS + n - 1);
			if (rb && (st || m[0])) begin
				mr = mr + (MANT_W+1)'(1);
				if (mr[MANT_W]) begin
					mr = mr >> 1;
					e  = e + EXP_W'(1);
				end
			end
			t[s] = {1'b0, e, mr[FRAC_W-1:0]};
			p = (p << 3) + (p << 1);
		end
		return t;
	endfunction

	localparam den_table_t DEN_TABLE = build_den_table();

endpackage

/* rtl/core/sdd_if.sv */
// Valid/ready channel interfaces for the converter's input and result transactions.
// Depends on sdd_pkg for field widths.
interface sdd_in_if;
	logic                        valid;
	logic                        ready;
	logic [sdd_pkg::WORD_W-1:0]  magnitude_low;
	logic [sdd_pkg::WORD_W-1:0]  magnitude_high;
	logic [sdd_pkg::SCALE_W-1:0] decimal_scale;
	logic                        positive;

	modport source (output valid, magnitude_low, magnitude_high, decimal_scale, positive,
		input ready);
	modport sink (input valid, magnitude_low, magnitude_high, decimal_scale, positive,
		output ready);
endinterface

interface sdd_out_if;
	logic                       valid;
	logic                       ready;
	logic [sdd_pkg::WORD_W-1:0] result_bits;

	modport source (output valid, result_bits, input ready);
	modport sink (input valid, result_bits, output ready);
endinterface

/* rtl/core/sdd_front.sv */
// Front end: accepts transactions, finds the magnitude's bit length, rounds it to a double
// and looks up the divisor double. Depends on sdd_pkg and sdd_if.
module sdd_front (
	input  logic            clk,
	input  logic            arst_n,
	sdd_in_if.sink          in_ch,
	output logic            push_valid,
	input  logic            push_ready,
	output sdd_pkg::entry_t push_entry
);
	import sdd_pkg::*;

	logic                 s1_valid;
	logic [MAG_W-1:0]     mag_s1;
	logic [SCALE_W-1:0]   scale_s1;
	logic                 pos_s1;
	logic [LEN_W-1:0]     len_s1;

	logic [WORD_W-1:0]    word;
	logic [LEN_W-1:0]     wlen;
	logic [LEN_W-1:0]     len_d;
	logic [SCALE_W-1:0]   scale_d;
	logic [LEN_W-1:0]     sh;
	logic [MAG_W-1:0]     norm;
	logic [MANT_W-1:0]    mant;
	logic                 rb;
	logic                 st;
	logic [MANT_W:0]      mr;
	logic [WORD_W-1:0]    den;

	// bit length of the 128-bit magnitude, and the scale clamped to MAX_SCALE
	always_comb begin
		word = (in_ch.magnitude_high != '0) ? in_ch.magnitude_high : in_ch.magnitude_low;
		wlen = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (word[i]) wlen = LEN_W'(i + 1);
		end
		len_d = (in_ch.magnitude_high != '0) ? wlen + LEN_W'(WORD_W) : wlen;
		scale_d = (in_ch.decimal_scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
			: in_ch.decimal_scale;
	end

	assign in_ch.ready = !s1_valid || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mag_s1   <= {in_ch.magnitude_high, in_ch.magnitude_low};
			scale_s1 <= scale_d;
			pos_s1   <= in_ch.positive;
			len_s1   <= len_d;
		end
	end

	// normalize, round to nearest even, attach the divisor
	always_comb begin
		sh   = LEN_W'(MAG_W) - len_s1;
		norm = mag_s1 << sh;
		mant = norm[MAG_W-1 -: MANT_W];
		rb   = norm[MAG_W-1-MANT_W];
		st   = |norm[MAG_W-2-MANT_W:0];
		mr   = {1'b0, mant};
		if (rb && (st || mant[0])) mr = mr + (MANT_W+1)'(1);
		den  = DEN_TABLE[scale_s1];

		push_entry.num_mant = mr[MANT_W] ? mr[MANT_W:1] : mr[MANT_W-1:0];
		push_entry.num_exp  = EXP_W'(BIAS - 1) + EXP_W'(len_s1) + EXP_W'(mr[MANT_W]);
		push_entry.den_mant = {1'b1, den[FRAC_W-1:0]};
		push_entry.den_exp  = den[WORD_W-2 -: EXP_W];
		push_entry.num_zero = (len_s1 == '0);
		push_entry.positive = pos_s1;
	end

	assign push_valid = s1_valid;

endmodule

/* rtl/core/sdd_queue.sv */
// Short queue between front and back so each side stalls on its own.
// Depends on sdd_pkg.
module sdd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sdd_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sdd_pkg::entry_t pop_entry
);
	import sdd_pkg::*;

	entry_t              mem [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_entry;
	end

endmodule

/* rtl/core/sdd_back.sv */
// Back end: pipelined restoring divider, one quotient bit per stage, then rounding,
// sign and packing into the output register. Depends on sdd_pkg and sdd_if.
module sdd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  sdd_pkg::entry_t pop_entry,
	sdd_out_if.source       out_ch
);
	import sdd_pkg::*;

	logic                 en;
	logic                 div_valid_q [0:DIV_STEPS];
	logic [REM_W-1:0]     div_rem_q   [0:DIV_STEPS];
	logic [QUO_W-1:0]     div_quo_q   [0:DIV_STEPS];
	logic [MANT_W-1:0]    div_den_q   [0:DIV_STEPS];
	logic [EXPC_W-1:0]    div_exp_q   [0:DIV_STEPS];
	logic                 div_zero_q  [0:DIV_STEPS];
	logic                 div_pos_q   [0:DIV_STEPS];

	logic [REM_W-1:0]     rem_nx [0:DIV_STEPS-1];
	logic [QUO_W-1:0]     quo_nx [0:DIV_STEPS-1];

	logic                 ge;
	logic [REM_W-1:0]     rem0;
	logic [EXPC_W-1:0]    exp0;

	logic [MANT_W-1:0]    fm;
	logic                 frb;
	logic                 fst;
	logic [MANT_W:0]      fmr;
	logic [EXPC_W-1:0]    fexp;
	logic [WORD_W-1:0]    res;

	// whole pipeline moves unless the result register is held
	assign en        = !out_ch.valid || out_ch.ready;
	assign pop_ready = en;

	// align so the quotient lands in [1,2)
	always_comb begin
		ge   = (pop_entry.num_mant >= pop_entry.den_mant);
		rem0 = ge ? {1'b0, pop_entry.num_mant} : {pop_entry.num_mant, 1'b0};
		exp0 = EXPC_W'(pop_entry.num_exp) - EXPC_W'(pop_entry.den_exp) + EXPC_W'(BIAS)
			- EXPC_W'(!ge);
	end

	// one restoring step per stage
	always_comb begin
		for (int i = 0; i < DIV_STEPS; i++) begin
			if (div_rem_q[i] >= {1'b0, div_den_q[i]}) begin
				rem_nx[i] = (div_rem_q[i] - {1'b0, div_den_q[i]}) << 1;
				quo_nx[i] = {div_quo_q[i][QUO_W-2:0], 1'b1};
			end else begin
				rem_nx[i] = div_rem_q[i] << 1;
				quo_nx[i] = {div_quo_q[i][QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++) div_valid_q[i] <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (en) begin
			div_valid_q[0] <= pop_valid;
			for (int i = 0; i < DIV_STEPS; i++) div_valid_q[i+1] <= div_valid_q[i];
			out_ch.valid <= div_valid_q[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_q[0]  <= rem0;
			div_quo_q[0]  <= '0;
			div_den_q[0]  <= pop_entry.den_mant;
			div_exp_q[0]  <= exp0;
			div_zero_q[0] <= pop_entry.num_zero;
			div_pos_q[0]  <= pop_entry.positive;
			for (int i = 0; i < DIV_STEPS; i++) begin
				div_rem_q[i+1]  <= rem_nx[i];
				div_quo_q[i+1]  <= quo_nx[i];
				div_den_q[i+1]  <= div_den_q[i];
				div_exp_q[i+1]  <= div_exp_q[i];
				div_zero_q[i+1] <= div_zero_q[i];
				div_pos_q[i+1]  <= div_pos_q[i];
			end
			out_ch.result_bits <= res;
		end
	end

	// round to nearest even and pack
	always_comb begin
		fm   = div_quo_q[DIV_STEPS][QUO_W-1:2];
		frb  = div_quo_q[DIV_STEPS][1];
		fst  = div_quo_q[DIV_STEPS][0] || (div_rem_q[DIV_STEPS] != '0);
		fmr  = {1'b0, fm};
		fexp = div_exp_q[DIV_STEPS];
		if (frb && (fst || fm[0])) begin
			fmr = fmr + (MANT_W+1)'(1);
			if (fmr[MANT_W]) begin
				fmr  = fmr >> 1;
				fexp = fexp + EXPC_W'(1);
			end
		end
		if (div_zero_q[DIV_STEPS]) begin
			res = {!div_pos_q[DIV_STEPS], (WORD_W-1)'(0)};
		end else begin
			res = {!div_pos_q[DIV_STEPS], fexp[EXP_W-1:0], fmr[FRAC_W-1:0]};
		end
	end

	// leading quotient bit is always set after alignment
	a_quo_norm: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid_q[DIV_STEPS] && !div_zero_q[DIV_STEPS] |-> div_quo_q[DIV_STEPS][QUO_W-1])
		else $error("quotient not normalized");

	// partial remainder stays below twice the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid_q[DIV_STEPS] |-> div_rem_q[DIV_STEPS] < {div_den_q[DIV_STEPS], 1'b0})
		else $error("remainder out of range");

	// any nonzero result lies between 2^-128 and 2^130
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.result_bits[WORD_W-2:0] != '0) |->
		out_ch.result_bits[WORD_W-2 -: EXP_W] >= EXP_W'(BIAS - 128) &&
		out_ch.result_bits[WORD_W-2 -: EXP_W] <= EXP_W'(BIAS + 129))
		else $error("result exponent out of range");

endmodule

/* rtl/core/scaled_decimal_to_double.sv */
// Top level of the scaled decimal to double converter: front end, queue and divider back end.
// Depends on sdd_pkg, sdd_if, sdd_front, sdd_queue and sdd_back.
//
// Converts a 128-bit unsigned magnitude, a decimal scale (above 38 treated as 38) and a sign
// flag into IEEE double bits: the magnitude and ten to the scale are each rounded to double,
// divided with round to nearest even, and negated when positive is 0 (a zero magnitude then
// gives negative zero). One transaction is accepted every cycle and one result leaves every
// cycle when the sink keeps ready high. The path runs through one front stage, the
// four-entry queue, 55 divider stages (one quotient bit each) plus its entry stage, and
// the result register. While a result waits the whole divider holds, and the input side
// keeps accepting only until the queue and the front stage have filled up.
module scaled_decimal_to_double (
	input  logic       clk,
	input  logic       arst_n,
	sdd_in_if.sink     in_ch,
	sdd_out_if.source  out_ch
);
	import sdd_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_entry;

	sdd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	sdd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	sdd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.out_ch     (out_ch)
	);

endmodule

/* tb/sv/scaled_decimal_to_double_test.sv */
// Self-checking testbench for scaled_decimal_to_double: directed and random decimals in, double bits out.
// Depends on sdd_pkg, sdd_in_if, sdd_out_if and the converter RTL.
module scaled_decimal_to_double_test;
	import sdd_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 5;
	localparam int DRAIN_CYC   = 80;
	localparam int LIMIT_CYC   = 2000000;
	localparam int RAND_ITEMS  = 1950;
	localparam int LONG_STALL  = 400;

	typedef struct {
		logic [WORD_W-1:0]  mag_lo;
		logic [WORD_W-1:0]  mag_hi;
		logic [SCALE_W-1:0] scale;
		logic               positive;
	} decimal_t;

	// round a 128-bit unsigned integer to double bits, ties to even
	function automatic logic [WORD_W-1:0] wide_to_bits(logic [MAG_W-1:0] v);
		int               n;
		int               sh;
		logic [MAG_W-1:0] shifted;
		logic [MANT_W:0]  mant;
		logic             half;
		logic             sticky;
		n = 0;
		for (int b = 0; b < MAG_W; b++) begin
			if (v[b]) n = b + 1;
		end
		if (n == 0) return '0;
		if (n <= MANT_W) begin
			shifted = v << (MANT_W - n);
			mant    = {1'b0, shifted[MANT_W-1:0]};
		end else begin
			sh      = n - MANT_W;
			shifted = v >> sh;
			mant    = {1'b0, shifted[MANT_W-1:0]};
			half    = v[sh-1];
			sticky  = (v & ((MAG_W'(1) << (sh - 1)) - MAG_W'(1))) != '0;
			if (half && (sticky || mant[0])) begin
				mant = mant + 1'b1;
				if (mant[MANT_W]) begin
					mant = mant >> 1;
					n++;
				end
			end
		end
		return {1'b0, EXP_W'(BIAS + n - 1), mant[FRAC_W-1:0]};
	endfunction

	// expected double bits of one scaled decimal
	function automatic logic [WORD_W-1:0] decimal_to_bits(decimal_t d);
		int                s;
		logic [MAG_W-1:0]  pow10;
		real               num;
		real               den;
		logic [WORD_W-1:0] q;
		s = (d.scale > MAX_SCALE) ? MAX_SCALE : int'(d.scale);
		pow10 = MAG_W'(1);
		for (int i = 0; i < s; i++) pow10 = (pow10 << 3) + (pow10 << 1);
		num = $bitstoreal(wide_to_bits({d.mag_hi, d.mag_lo}));
		den = $bitstoreal(wide_to_bits(pow10));
		q = $realtobits(num / den);
		// sign flip on the bits keeps negative zero
		if (!d.positive) q[WORD_W-1] = ~q[WORD_W-1];
		return q;
	endfunction

	class result_board;
		logic [WORD_W-1:0] expected_q[$];
		int                errors = 0;

		function void note_input(decimal_t d);
			expected_q.push_back(decimal_to_bits(d));
		endfunction

		function void check_result(logic [WORD_W-1:0] got);
			logic [WORD_W-1:0] want;
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction result_bits=%h", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				$error("result_bits expected %h actual %h", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	sdd_in_if  in_ch();
	sdd_out_if out_ch();
	result_board board;
	int stall_req;
	int stall_left;
	int gap_left;
	longint cycles;

	scaled_decimal_to_double u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// random gap: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver: check each result transaction, then choose ready
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) board.check_result(out_ch.result_bits);
			if (stall_req > 0) begin
				stall_left = stall_req;
				stall_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ch.ready <= 1'b0;
			end else begin
				gap_left = pick_gap();
				out_ch.ready <= (gap_left == 0);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		if (cycles > LIMIT_CYC) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// offer one transaction after a gap and hold it until accepted
	task automatic send_decimal(decimal_t d, int gap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.magnitude_low  <= d.mag_lo;
		in_ch.magnitude_high <= d.mag_hi;
		in_ch.decimal_scale  <= d.scale;
		in_ch.positive       <= d.positive;
		in_ch.valid          <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_input(d);
	endtask

	task automatic send_fields(logic [MAG_W-1:0] m, int s, bit p);
		decimal_t d;
		d.mag_lo   = m[WORD_W-1:0];
		d.mag_hi   = m[MAG_W-1:WORD_W];
		d.scale    = SCALE_W'(s);
		d.positive = p;
		send_decimal(d, pick_gap());
	endtask

	// random decimal with a random magnitude width, sometimes an exact rounding tie
	task automatic send_random();
		logic [MAG_W-1:0] m;
		logic [MANT_W:0]  tie;
		int               w;
		int               s;
		m = {$urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(0, 7) == 0) begin
			tie = {1'b1, (MANT_W-1)'({$urandom, $urandom}), 1'b1};
			m = MAG_W'(tie) << $urandom_range(0, MAG_W - MANT_W - 1);
		end else begin
			w = $urandom_range(0, MAG_W);
			if (w < MAG_W) m = m & ((MAG_W'(1) << w) - MAG_W'(1));
		end
		s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, MAX_SCALE);
		send_fields(m, s, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		board = new();
		stall_req = 0;
		stall_left = 0;
		gap_left = 0;
		cycles = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.magnitude_low = '0;
		in_ch.magnitude_high = '0;
		in_ch.decimal_scale = '0;
		in_ch.positive = 1'b0;
		out_ch.ready = 1'b0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zeros, extremes, saturated scales, rounding ties
		send_fields('0, 0, 1'b1);
		send_fields('0, 0, 1'b0);
		send_fields('0, MAX_SCALE, 1'b0);
		send_fields('1, 0, 1'b1);
		send_fields('1, MAX_SCALE, 1'b0);
		send_fields('1, 63, 1'b1);
		send_fields(MAG_W'(1), 0, 1'b1);
		send_fields(MAG_W'(1), MAX_SCALE, 1'b1);
		send_fields(MAG_W'(1), 39, 1'b0);
		send_fields(MAG_W'(1), 32, 1'b1);
		send_fields(MAG_W'(12345), 2, 1'b0);
		send_fields(MAG_W'(1) << (MAG_W - 1), 19, 1'b1);
		send_fields((MAG_W'(1) << 53) + 1, 0, 1'b1);
		send_fields((MAG_W'(1) << 53) + 3, 0, 1'b1);
		send_fields((MAG_W'(1) << 54) - 1, 1, 1'b0);
		send_fields({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 0, 1'b1);
		send_fields({64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 20, 1'b0);
		send_fields({64'h0000_0000_0000_0001, 64'h0}, 38, 1'b1);
		send_fields(MAG_W'(64'd10000000000000000000), 19, 1'b1);
		send_fields(MAG_W'(7), 1, 1'b0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 600) stall_req = LONG_STALL;
			if (i == 1200) begin
				in_ch.valid <= 1'b0;
				while (board.expected_q.size() != 0) @(posedge clk);
			end
			send_random();
		end
		in_ch.valid <= 1'b0;

		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/sdd_pkg.sv
rtl/core/sdd_if.sv
rtl/core/sdd_front.sv
rtl/core/sdd_queue.sv
rtl/core/sdd_back.sv
rtl/core/scaled_decimal_to_double.sv
tb/sv/scaled_decimal_to_double_test.sv
